### design/gcd_pkg.sv
// Shared types, fixed-point constants and helper functions for the
// great-circle distance pipeline. Used by every module in this folder.
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

   // fixed-point format and CORDIC length
   localparam int FRAC  = 30;
   localparam int ITERS = 32;
   localparam int CW    = 34;

   typedef logic signed [CW-1:0] cval_type;

   localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452954;

   localparam cval_type GAIN    = CW'(GAIN_Q62 >> (62 - FRAC));
   localparam cval_type ONE     = CW'(64'd1 << FRAC);
   localparam cval_type HALF_PI = CW'(PI_Q60 >> (61 - FRAC));

   // half-microdegrees to radians, pi/360e6 in Q(FRAC+32), split for two products
   localparam logic [63:0] DQ     = PI_Q60 / 64'd360000000;
   localparam logic [63:0] DR     = PI_Q60 % 64'd360000000;
   localparam logic [63:0] D_FULL = ((DQ << 12) + ((DR << 12) / 64'd360000000)) >> (40 - FRAC);
   localparam logic [17:0] DH     = 18'(D_FULL >> 18);
   localparam logic [17:0] DL     = D_FULL[17:0];

   // unit conversion factors, Q32
   localparam logic [32:0] F_BASE     = 33'h1_0000_0000;
   localparam logic [32:0] F_STATUTE  = 33'd2668768940;
   localparam logic [32:0] F_NAUTICAL = 33'd2319096797;

   typedef enum logic [1:0] {
      UNIT_BASE     = 2'd0,
      UNIT_STATUTE  = 2'd1,
      UNIT_NAUTICAL = 2'd2
   } unit_type;

   typedef enum logic {
      CSR_RADIUS = 1'b0,
      CSR_UNIT   = 1'b1
   } csr_index_type;

   // x / (2k+1) for the Taylor terms of the arctangent table
   function automatic logic [63:0] odd_div(logic [63:0] x, int k);
      logic [63:0] r;
      case (k)
         0:  r = x;
         1:  r = x / 64'd3;
         2:  r = x / 64'd5;
         3:  r = x / 64'd7;
         4:  r = x / 64'd9;
         5:  r = x / 64'd11;
         6:  r = x / 64'd13;
         7:  r = x / 64'd15;
         8:  r = x / 64'd17;
         9:  r = x / 64'd19;
         10: r = x / 64'd21;
         11: r = x / 64'd23;
         12: r = x / 64'd25;
         13: r = x / 64'd27;
         14: r = x / 64'd29;
         15: r = x / 64'd31;
         16: r = x / 64'd33;
         17: r = x / 64'd35;
         18: r = x / 64'd37;
         19: r = x / 64'd39;
         20: r = x / 64'd41;
         21: r = x / 64'd43;
         22: r = x / 64'd45;
         23: r = x / 64'd47;
         24: r = x / 64'd49;
         25: r = x / 64'd51;
         26: r = x / 64'd53;
         27: r = x / 64'd55;
         28: r = x / 64'd57;
         29: r = x / 64'd59;
         default: r = x / 64'd61;
      endcase
      return r;
   endfunction

   // atan(2^-i) in Q(FRAC), from a Q62 Taylor sum
   function automatic cval_type atan_entry(int i);
      int          k;
      logic [63:0] v;
      logic [63:0] term;
      v = 64'd0;
      if (i == 0) begin
         v = PI_Q60;
      end else begin
         for (k = 0; k <= 30; k++) begin
            if (i * (2 * k + 1) <= 62) begin
               term = odd_div(64'd1 << (62 - i * (2 * k + 1)), k);
               v    = (k % 2 == 1) ? v - term : v + term;
            end
         end
      end
      return CW'(v >> (62 - FRAC));
   endfunction

   // Q(FRAC) product, truncated toward zero
   function automatic cval_type mulq(cval_type a, cval_type b);
      logic [CW-1:0]   ua;
      logic [CW-1:0]   ub;
      logic [2*CW-1:0] p;
      logic [CW-1:0]   r;
      ua = a[CW-1] ? CW'(-a) : CW'(a);
      ub = b[CW-1] ? CW'(-b) : CW'(b);
      p  = ua * ub;
      r  = p[FRAC +: CW];
      return (a[CW-1] ^ b[CW-1]) ? cval_type'(-r) : cval_type'(r);
   endfunction

endpackage

`default_nettype wire

### design/gcd_sincos.sv
// Sine and cosine of an angle in half-microdegrees: quadrant fold, conversion
// to Q30 radians, then one rotation-mode CORDIC stage per register. Uses gcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcd_sincos (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_vld,
   input  wire logic signed [29:0]     angle,
   output logic                        out_vld,
   output gcd_pkg::cval_type           sin_val,
   output gcd_pkg::cval_type           cos_val
);
   import gcd_pkg::*;

   localparam logic signed [30:0] TURN  = 31'sd720000000;
   localparam logic signed [30:0] HALF  = 31'sd360000000;
   localparam logic signed [30:0] QUART = 31'sd180000000;

   // fold into one quadrant
   logic signed [30:0] hx;
   logic signed [30:0] r;
   logic [30:0]        mag;
   logic [27:0]        m_in;
   logic               cneg_in;

   always_comb begin
      hx = 31'(angle);
      if (hx >= HALF) begin
         r = hx - TURN;
      end else if (hx < -HALF) begin
         r = hx + TURN;
      end else begin
         r = hx;
      end
      mag     = r[30] ? 31'(-r) : 31'(r);
      cneg_in = 1'b0;
      m_in    = mag[27:0];
      if ($signed(mag) > QUART) begin
         m_in    = 28'(HALF - $signed(mag));
         cneg_in = 1'b1;
      end
   end

   logic [27:0] m_ff;
   logic        neg_a_ff, cneg_a_ff, vld_a_ff;
   logic [45:0] ph_ff, pl_ff;
   logic        neg_b_ff, cneg_b_ff, vld_b_ff;
   logic [63:0] prod;

   assign prod = {ph_ff, 18'b0} + 64'(pl_ff);

   cval_type x_ff [ITERS+1];
   cval_type y_ff [ITERS+1];
   cval_type z_ff [ITERS+1];
   logic     neg_ff  [ITERS+1];
   logic     cneg_ff [ITERS+1];
   logic     vld_ff  [ITERS+1];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff  <= 1'b0;
         vld_b_ff  <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_a_ff  <= in_vld;
         vld_b_ff  <= vld_a_ff;
         vld_ff[0] <= vld_b_ff;
      end
   end

   // fold, radian conversion and CORDIC seed
   always_ff @(posedge clock) begin
      if (en) begin
         m_ff       <= m_in;
         neg_a_ff   <= r[30];
         cneg_a_ff  <= cneg_in;
         ph_ff      <= m_ff * DH;
         pl_ff      <= m_ff * DL;
         neg_b_ff   <= neg_a_ff;
         cneg_b_ff  <= cneg_a_ff;
         x_ff[0]    <= GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= cval_type'({2'b00, prod[63:32]});
         neg_ff[0]  <= neg_b_ff;
         cneg_ff[0] <= cneg_b_ff;
      end
   end

   // rotation stages
   for (genvar i = 0; i < ITERS; i++) begin : g_stage
      localparam cval_type AT = atan_entry(i);
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - AT;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + AT;
            end
            neg_ff[i+1]  <= neg_ff[i];
            cneg_ff[i+1] <= cneg_ff[i];
         end
      end
   end

   assign out_vld = vld_ff[ITERS];
   assign sin_val = neg_ff[ITERS]  ? cval_type'(-y_ff[ITERS]) : y_ff[ITERS];
   assign cos_val = cneg_ff[ITERS] ? cval_type'(-x_ff[ITERS]) : x_ff[ITERS];

endmodule

`default_nettype wire

### design/gcd_sqrt.sv
// Two square roots floor(sqrt(v * 2^30)) side by side, one result bit per
// register stage (restoring digit recurrence). Uses gcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcd_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_vld,
   input  wire logic [30:0] a_val,
   input  wire logic [30:0] b_val,
   output logic             out_vld,
   output logic [30:0]      a_root,
   output logic [30:0]      b_root
);
   import gcd_pkg::*;

   localparam int STEPS = FRAC + 1;

   logic [61:0] ra_ff [STEPS+1];
   logic [61:0] qa_ff [STEPS+1];
   logic [61:0] rb_ff [STEPS+1];
   logic [61:0] qb_ff [STEPS+1];
   logic        vld_ff [STEPS+1];

   // load radicands
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ra_ff[0] <= {1'b0, a_val, 30'b0};
         rb_ff[0] <= {1'b0, b_val, 30'b0};
         qa_ff[0] <= '0;
         qb_ff[0] <= '0;
      end
   end

   // one root bit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [61:0] BIT = 62'd1 << (2 * FRAC - 2 * k);
      logic [61:0] ta, tb;
      assign ta = qa_ff[k] + BIT;
      assign tb = qb_ff[k] + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (ra_ff[k] >= ta) begin
               ra_ff[k+1] <= ra_ff[k] - ta;
               qa_ff[k+1] <= (qa_ff[k] >> 1) + BIT;
            end else begin
               ra_ff[k+1] <= ra_ff[k];
               qa_ff[k+1] <= qa_ff[k] >> 1;
            end
            if (rb_ff[k] >= tb) begin
               rb_ff[k+1] <= rb_ff[k] - tb;
               qb_ff[k+1] <= (qb_ff[k] >> 1) + BIT;
            end else begin
               rb_ff[k+1] <= rb_ff[k];
               qb_ff[k+1] <= qb_ff[k] >> 1;
            end
         end
      end
   end

   assign out_vld = vld_ff[STEPS];
   assign a_root  = qa_ff[STEPS][30:0];
   assign b_root  = qb_ff[STEPS][30:0];

endmodule

`default_nettype wire

### design/gcd_atan.sv
// Arctangent of y/x for x, y >= 0 by vectoring-mode CORDIC, one stage per
// register. Uses gcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcd_atan (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_vld,
   input  wire logic [30:0]       y_val,
   input  wire logic [30:0]       x_val,
   output logic                   out_vld,
   output gcd_pkg::cval_type      angle
);
   import gcd_pkg::*;

   cval_type x_ff [ITERS+1];
   cval_type y_ff [ITERS+1];
   cval_type z_ff [ITERS+1];
   logic     vld_ff [ITERS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= cval_type'({3'b000, x_val});
         y_ff[0] <= cval_type'({3'b000, y_val});
         z_ff[0] <= '0;
      end
   end

   // vectoring stages: drive y toward zero
   for (genvar i = 0; i < ITERS; i++) begin : g_stage
      localparam cval_type AT = atan_entry(i);
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + AT;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - AT;
            end
         end
      end
   end

   assign out_vld = vld_ff[ITERS];
   assign angle   = z_ff[ITERS];

endmodule

`default_nettype wire

### design/great_circle_distance.sv
// Haversine great-circle distance. One request (two positions in signed
// microdegrees) can enter every clock cycle while the pipeline advances, and
// passes 35 sine/cosine CORDIC, 3 product, 32 square-root, 33 arctangent
// CORDIC and 3 scaling and rounding stages. The whole pipeline holds while
// a result waits at the output. The user must write radius and unit through
// the csr_ port only while no request is in flight; the block does not
// enforce this. Depends on gcd_pkg, gcd_sincos, gcd_sqrt and gcd_atan.
`timescale 1ns / 1ps
`default_nettype none

module great_circle_distance (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // from_lat[27:0], from_lon[56:28], to_lat[84:57], to_lon[113:85], zero pad
   input  wire logic [119:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // distance_hundredths[24:0], zero pad
   output logic [31:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata
);
   import gcd_pkg::*;

   localparam logic [26:0] OUT_MAX = 27'd33554431;

   // configuration registers
   logic [15:0] earth_radius_ff;
   logic [1:0]  unit_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         earth_radius_ff <= 16'd6371;
         unit_scale_ff   <= UNIT_BASE;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RADIUS: earth_radius_ff <= csr_wdata;
            CSR_UNIT:   unit_scale_ff   <= csr_wdata[1:0];
            default:    earth_radius_ff <= earth_radius_ff;
         endcase
      end
   end

   // global advance: the output register frees or is taken
   logic rsp_tvalid_ff;
   logic en;
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en && !reset;

   // request fields and angles in half-microdegrees
   logic signed [27:0] from_lat, to_lat;
   logic signed [28:0] from_lon, to_lon;
   logic signed [29:0] ang_lat1, ang_lat2, ang_dlat, ang_dlon;

   assign from_lat = req_tdata[27:0];
   assign from_lon = req_tdata[56:28];
   assign to_lat   = req_tdata[84:57];
   assign to_lon   = req_tdata[113:85];
   assign ang_lat1 = 30'(signed'({from_lat, 1'b0}));
   assign ang_lat2 = 30'(signed'({to_lat, 1'b0}));
   assign ang_dlat = 30'(to_lat) - 30'(from_lat);
   assign ang_dlon = 30'(to_lon) - 30'(from_lon);

   logic     sc_vld;
   cval_type c1, c2, sd1, sd2;

   gcd_sincos u_lat1 (
      .clock(clock), .reset(reset), .en(en), .in_vld(req_tvalid),
      .angle(ang_lat1), .out_vld(sc_vld), .sin_val(), .cos_val(c1)
   );
   gcd_sincos u_lat2 (
      .clock(clock), .reset(reset), .en(en), .in_vld(req_tvalid),
      .angle(ang_lat2), .out_vld(), .sin_val(), .cos_val(c2)
   );
   gcd_sincos u_dlat (
      .clock(clock), .reset(reset), .en(en), .in_vld(req_tvalid),
      .angle(ang_dlat), .out_vld(), .sin_val(sd1), .cos_val()
   );
   gcd_sincos u_dlon (
      .clock(clock), .reset(reset), .en(en), .in_vld(req_tvalid),
      .angle(ang_dlon), .out_vld(), .sin_val(sd2), .cos_val()
   );

   // haversine term a, three product stages
   cval_type p1_ff, p2_ff, p3_ff, q1_ff, p4_ff;
   logic     m1_vld_ff, m2_vld_ff, m3_vld_ff;
   logic [30:0] a_ff, b_ff;
   cval_type sum;
   logic [30:0] a_in;

   assign sum  = q1_ff + p4_ff;
   assign a_in = sum[CW-1] ? 31'd0 : (sum > ONE ? ONE[30:0] : sum[30:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= sc_vld;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= mulq(sd1, sd1);
         p2_ff <= mulq(c1, c2);
         p3_ff <= mulq(sd2, sd2);
         q1_ff <= p1_ff;
         p4_ff <= mulq(p2_ff, p3_ff);
         a_ff  <= a_in;
         b_ff  <= ONE[30:0] - a_in;
      end
   end

   // central angle: atan2(sqrt(a), sqrt(1-a))
   logic        sq_vld;
   logic [30:0] sqrt_a, sqrt_b;
   logic        at_vld;
   cval_type    z;

   gcd_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_vld(m3_vld_ff),
      .a_val(a_ff), .b_val(b_ff), .out_vld(sq_vld),
      .a_root(sqrt_a), .b_root(sqrt_b)
   );

   gcd_atan u_atan (
      .clock(clock), .reset(reset), .en(en), .in_vld(sq_vld),
      .y_val(sqrt_a), .x_val(sqrt_b), .out_vld(at_vld), .angle(z)
   );

   // scale by radius and unit, round to hundredths
   logic [30:0] zc;
   logic [47:0] dist_ff;
   logic [32:0] factor;
   logic [48:0] ph_ff;
   logic [64:0] pl_ff;
   logic [49:0] e;
   logic [57:0] e200;
   logic [26:0] h;
   logic        f1_vld_ff, f2_vld_ff;

   assign zc = z[CW-1] ? 31'd0 : (z > HALF_PI ? HALF_PI[30:0] : z[30:0]);

   always_comb begin
      case (unit_type'(unit_scale_ff))
         UNIT_STATUTE:  factor = F_STATUTE;
         UNIT_NAUTICAL: factor = F_NAUTICAL;
         default:       factor = F_BASE;
      endcase
   end

   assign e    = 50'(ph_ff) + 50'(pl_ff[64:32]);
   assign e200 = 58'(e) * 58'd200;
   assign h    = 27'((e200[57:30] + 28'd1) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff     <= 1'b0;
         f2_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff     <= at_vld;
         f2_vld_ff     <= f1_vld_ff;
         rsp_tvalid_ff <= f2_vld_ff;
      end
   end

   logic [24:0] dist_out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff     <= earth_radius_ff * {zc, 1'b0};
         ph_ff       <= dist_ff[47:32] * factor;
         pl_ff       <= dist_ff[31:0] * factor;
         dist_out_ff <= (h > OUT_MAX) ? OUT_MAX[24:0] : h[24:0];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, dist_out_ff};

endmodule

`default_nettype wire
